### rtl/iq_sample_agc_unit_defines.svh
// Assertion macros shared by the IQ sample AGC RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef IQ_SAMPLE_AGC_UNIT_DEFINES_SVH
`define IQ_SAMPLE_AGC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ISAGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ISAGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/isagc_pkg.sv
// Types, constants and microcode program of the IQ sample AGC.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package isagc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 32;
   localparam int RATE_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 64;
   localparam int NUM_STEPS = 10;
   localparam int STEP_W    = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE = 4'd0;
   localparam step_type STEP_LAST = 4'd9;

   localparam logic signed [GAIN_W-1:0] START_GAIN_RST = 32'sd65536;
   localparam logic signed [GAIN_W-1:0] CEILING_RST    = 32'sh7FFF_FFFF;
   localparam logic [RATE_W-1:0]        RATE_RST       = 24'd1678;

   localparam logic signed [PROD_W-1:0] ONE_Q30    = 64'sd1073741824;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;
   localparam logic signed [PROD_W-1:0] SAT_HI_EXT = 64'sd32767;
   localparam logic signed [PROD_W-1:0] SAT_LO_EXT = -64'sd32768;
   localparam logic signed [SAMPLE_W-1:0] SAT_HI  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_LO  = 16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_GAIN   = 2'd0,
      CSR_GAIN_CEILING = 2'd1,
      CSR_ADAPT_RATE   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OPA_NONE,
      OPA_XI,
      OPA_XQ,
      OPA_OI,
      OPA_OQ,
      OPA_RATE,
      OPA_GAIN
   } opa_sel_type;

   typedef enum logic [2:0] {
      OPB_NONE,
      OPB_GAIN,
      OPB_OI,
      OPB_OQ,
      OPB_ERR,
      OPB_Z
   } opb_sel_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_OI,
      WB_OQ,
      WB_PWR,
      WB_ERR,
      WB_Z,
      WB_GAIN
   } wb_sel_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_DONE
   } seq_type;

   typedef struct packed {
      opa_sel_type a_sel;
      opb_sel_type b_sel;
      logic        mul_en;
      wb_sel_type  wb_sel;
      seq_type     seq;
      step_type    target;
   } ctrl_word_type;

   localparam ctrl_word_type UCODE [NUM_STEPS] = '{
      '{OPA_NONE, OPB_NONE, 1'b0, WB_NONE, SEQ_WAIT_REQ, STEP_IDLE},
      '{OPA_XI,   OPB_GAIN, 1'b1, WB_NONE, SEQ_NEXT,     STEP_IDLE},
      '{OPA_XQ,   OPB_GAIN, 1'b1, WB_OI,   SEQ_NEXT,     STEP_IDLE},
      '{OPA_OI,   OPB_OI,   1'b1, WB_OQ,   SEQ_NEXT,     STEP_IDLE},
      '{OPA_OQ,   OPB_OQ,   1'b1, WB_PWR,  SEQ_NEXT,     STEP_IDLE},
      '{OPA_NONE, OPB_NONE, 1'b0, WB_ERR,  SEQ_NEXT,     STEP_IDLE},
      '{OPA_RATE, OPB_ERR,  1'b1, WB_NONE, SEQ_NEXT,     STEP_IDLE},
      '{OPA_NONE, OPB_NONE, 1'b0, WB_Z,    SEQ_NEXT,     STEP_IDLE},
      '{OPA_GAIN, OPB_Z,    1'b1, WB_NONE, SEQ_NEXT,     STEP_IDLE},
      '{OPA_NONE, OPB_NONE, 1'b0, WB_GAIN, SEQ_DONE,     STEP_IDLE}
   };

endpackage

`default_nettype wire

### rtl/isagc_if.sv
// Valid/ready channel interfaces of the IQ sample AGC: sample request,
// result and register write. Depends on isagc_pkg for field widths.
`default_nettype none

interface isagc_req_if import isagc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_i;
   logic signed [SAMPLE_W-1:0] in_q;

   modport source (output valid, output in_i, output in_q, input ready);
   modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

interface isagc_rsp_if import isagc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_i;
   logic signed [SAMPLE_W-1:0] out_q;
   logic                       clipped;
   logic signed [GAIN_W-1:0]   gain_used;

   modport source (output valid, output out_i, output out_q, output clipped,
                   output gain_used, input ready);
   modport sink   (input valid, input out_i, input out_q, input clipped,
                   input gain_used, output ready);
endinterface

interface isagc_csr_if import isagc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [GAIN_W-1:0]    wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/iq_sample_agc_unit.sv
// IQ sample AGC top level: microcoded sequencer over one shared 32x32 multiplier.
// Depends on isagc_pkg, the channel interfaces and iq_sample_agc_unit_defines.svh.
//
// Usage:
//   req_chan  takes one complex sample (in_i, in_q, Q1.15) per request.
//   rsp_chan  returns one result per request: the sample scaled by the running
//             gain and saturated (out_i, out_q), the clipped flag and gain_used.
//   csr_chan  writes start_gain (0), gain_ceiling (1) or adapt_rate (2); it is
//             always ready, other indexes are dropped. Write only while idle.
//   Requests: a new request is taken only when the program is idle. The
//   ten-step program issues six products through the single multiplier, plus
//   writeback and accept steps, and the next sample needs the gain that the
//   last step produces.
//   Reset: the control and configuration registers take their reset values, the
//   running gain becomes 1.0 and no result is pending.
//   Stall: the result register holds its item while rsp_chan.ready is low;
//   the next request is taken and worked on meanwhile, and the program holds
//   at its last step until the result register is free.
`default_nettype none

`include "iq_sample_agc_unit_defines.svh"

module iq_sample_agc_unit import isagc_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   isagc_req_if.sink    req_chan,
   isagc_rsp_if.source  rsp_chan,
   isagc_csr_if.sink    csr_chan
);

   step_type                   step_ff, step_in;
   ctrl_word_type              cw;

   logic signed [GAIN_W-1:0]   start_gain_ff, start_gain_in;
   logic signed [GAIN_W-1:0]   ceiling_ff, ceiling_in;
   logic [RATE_W-1:0]          rate_ff, rate_in;
   logic signed [GAIN_W-1:0]   gain_ff, gain_in;

   logic signed [SAMPLE_W-1:0] xi_ff, xi_in, xq_ff, xq_in;
   logic signed [SAMPLE_W-1:0] oi_ff, oi_in, oq_ff, oq_in;
   logic                       clip_ff, clip_in;
   logic [GAIN_W-1:0]          acc_ff, acc_in;
   logic signed [GAIN_W-1:0]   err_ff, err_in;
   logic signed [GAIN_W-1:0]   z_ff, z_in;
   logic signed [PROD_W-1:0]   p_ff, p_in;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_i_ff, out_i_in, out_q_ff, out_q_in;
   logic                       out_clip_ff, out_clip_in;
   logic signed [GAIN_W-1:0]   out_gain_ff, out_gain_in;

   logic                       req_take, out_free, wb_en;
   logic signed [GAIN_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0]   rnd, zsum;
   logic signed [SAMPLE_W-1:0] sat_val;
   logic                       sat_hit;
   logic signed [GAIN_W+1:0]   pwr, err_full;
   logic                       ng_fits;
   logic signed [GAIN_W-1:0]   ng;

   assign cw       = UCODE[step_ff];
   assign req_take = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign wb_en    = (cw.seq != SEQ_DONE) || out_free;

   assign req_chan.ready     = (step_ff == STEP_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_i     = out_i_ff;
   assign rsp_chan.out_q     = out_q_ff;
   assign rsp_chan.clipped   = out_clip_ff;
   assign rsp_chan.gain_used = out_gain_ff;

   // operand select
   always_comb begin
      case (cw.a_sel)
         OPA_XI:   op_a = GAIN_W'(xi_ff);
         OPA_XQ:   op_a = GAIN_W'(xq_ff);
         OPA_OI:   op_a = GAIN_W'(oi_ff);
         OPA_OQ:   op_a = GAIN_W'(oq_ff);
         OPA_RATE: op_a = $signed({{(GAIN_W-RATE_W){1'b0}}, rate_ff});
         OPA_GAIN: op_a = gain_ff;
         default:  op_a = '0;
      endcase
      case (cw.b_sel)
         OPB_GAIN: op_b = gain_ff;
         OPB_OI:   op_b = GAIN_W'(oi_ff);
         OPB_OQ:   op_b = GAIN_W'(oq_ff);
         OPB_ERR:  op_b = err_ff;
         OPB_Z:    op_b = z_ff;
         default:  op_b = '0;
      endcase
   end

   // writeback arithmetic on the registered product
   always_comb begin
      rnd = (p_ff + ROUND_HALF) >>> 16;
      if (rnd > SAT_HI_EXT) begin
         sat_val = SAT_HI;
         sat_hit = 1'b1;
      end else if (rnd < SAT_LO_EXT) begin
         sat_val = SAT_LO;
         sat_hit = 1'b1;
      end else begin
         sat_val = rnd[SAMPLE_W-1:0];
         sat_hit = 1'b0;
      end
      pwr      = $signed({2'b00, acc_ff}) + $signed({2'b00, p_ff[GAIN_W-1:0]});
      err_full = ONE_Q30[GAIN_W+1:0] - pwr;
      zsum     = ONE_Q30 + (p_ff >>> RATE_W);
      ng_fits  = (p_ff[63] == p_ff[62]) && (p_ff[62] == p_ff[61]);
      ng       = p_ff[61:30];
   end

   always_comb begin
      step_in       = step_ff;
      start_gain_in = start_gain_ff;
      ceiling_in    = ceiling_ff;
      rate_in       = rate_ff;
      gain_in       = gain_ff;
      xi_in         = xi_ff;
      xq_in         = xq_ff;
      oi_in         = oi_ff;
      oq_in         = oq_ff;
      clip_in       = clip_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      z_in          = z_ff;
      p_in          = p_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_i_in      = out_i_ff;
      out_q_in      = out_q_ff;
      out_clip_in   = out_clip_ff;
      out_gain_in   = out_gain_ff;

      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_START_GAIN:   start_gain_in = $signed(csr_chan.wdata);
            CSR_GAIN_CEILING: ceiling_in    = $signed(csr_chan.wdata);
            CSR_ADAPT_RATE:   rate_in       = csr_chan.wdata[RATE_W-1:0];
            default:          ;
         endcase
      end

      case (cw.seq)
         SEQ_WAIT_REQ: begin
            if (req_take) begin
               step_in = step_ff + 4'd1;
               xi_in   = req_chan.in_i;
               xq_in   = req_chan.in_q;
            end
         end
         SEQ_DONE: begin
            if (out_free) begin
               step_in = cw.target;
            end
         end
         default: step_in = step_ff + 4'd1;
      endcase

      if (cw.mul_en) begin
         p_in = op_a * op_b;
      end

      if (wb_en) begin
         case (cw.wb_sel)
            WB_OI: begin
               oi_in   = sat_val;
               clip_in = sat_hit;
            end
            WB_OQ: begin
               oq_in   = sat_val;
               clip_in = clip_ff || sat_hit;
            end
            WB_PWR: acc_in = p_ff[GAIN_W-1:0];
            WB_ERR: err_in = err_full[GAIN_W-1:0];
            WB_Z:   z_in   = zsum[GAIN_W-1:0];
            WB_GAIN: begin
               if (!ng_fits) begin
                  gain_in = start_gain_ff;
               end else if (ng > ceiling_ff) begin
                  gain_in = ceiling_ff;
               end else begin
                  gain_in = ng;
               end
               out_valid_in = 1'b1;
               out_i_in     = oi_ff;
               out_q_in     = oq_ff;
               out_clip_in  = clip_ff;
               out_gain_in  = gain_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         start_gain_ff <= START_GAIN_RST;
         ceiling_ff    <= CEILING_RST;
         rate_ff       <= RATE_RST;
         gain_ff       <= START_GAIN_RST;
         out_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         start_gain_ff <= start_gain_in;
         ceiling_ff    <= ceiling_in;
         rate_ff       <= rate_in;
         gain_ff       <= gain_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xi_ff       <= xi_in;
      xq_ff       <= xq_in;
      oi_ff       <= oi_in;
      oq_ff       <= oq_in;
      clip_ff     <= clip_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      z_ff        <= z_in;
      p_ff        <= p_in;
      out_i_ff    <= out_i_in;
      out_q_ff    <= out_q_in;
      out_clip_ff <= out_clip_in;
      out_gain_ff <= out_gain_in;
   end

   `ISAGC_ASSERT_NOW(a_ready_only_idle, clock, reset, req_chan.ready, step_ff == STEP_IDLE, "request taken while program busy")
   `ISAGC_ASSERT_NEXT(a_accept_starts, clock, reset, req_chan.valid && req_chan.ready, step_ff == 4'd1, "accepted request did not start program")
   `ISAGC_ASSERT_NEXT(a_hold_on_stall, clock, reset, (step_ff == STEP_LAST) && out_valid_ff && !rsp_chan.ready, (step_ff == STEP_LAST) && rsp_chan.valid, "program left last step while result pending")
   `ISAGC_ASSERT_NOW(a_step_range, clock, reset, 1'b1, step_ff <= STEP_LAST, "step counter beyond program")

endmodule

`default_nettype wire
